// ===== hw/rtl/rae_pkg.sv =====
// ----------------------------------------------------------------------------
// rae_pkg
// Shared types and constants of the retriggerable alpha envelope.
// ----------------------------------------------------------------------------
package rae_pkg;

  localparam int unsigned COLOR_W = 8;
  localparam int unsigned TIME_W  = 14;
  localparam int unsigned NUM_W   = 22;  // dividend and quotient width
  localparam int unsigned CNT_W   = 5;   // holds NUM_W

  localparam logic [TIME_W-1:0]  ELAPSED_MAX  = 14'd10000;
  localparam logic [TIME_W-1:0]  TICK_MS      = 14'd10;
  localparam logic [COLOR_W-1:0] FULL_SCALE   = 8'd255;
  localparam logic [TIME_W-1:0]  ATTACK_RST   = 14'd100;
  localparam logic [TIME_W-1:0]  RELEASE_RST  = 14'd800;
  localparam logic [TIME_W-1:0]  HOLD_RST     = 14'd200;

  // A 14-bit time over 10 is (time * RECIP10) >> RECIP10_SH, exact over the
  // whole 14-bit range.
  localparam logic [15:0]  RECIP10    = 16'd52429;
  localparam int unsigned  RECIP10_SH = 19;

  localparam logic [1:0] CFG_ATTACK  = 2'd0;
  localparam logic [1:0] CFG_RELEASE = 2'd1;
  localparam logic [1:0] CFG_HOLD    = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_ATTACK  = 2'd1,
    PH_HOLD    = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

  typedef struct packed {
    logic               op;
    logic [COLOR_W-1:0] target_red;
    logic [COLOR_W-1:0] target_green;
    logic [COLOR_W-1:0] target_blue;
    logic [COLOR_W-1:0] target_alpha;
  } rae_in_t;

  typedef struct packed {
    logic [COLOR_W-1:0] out_red;
    logic [COLOR_W-1:0] out_green;
    logic [COLOR_W-1:0] out_blue;
    logic [COLOR_W-1:0] out_alpha;
    phase_t             phase;
  } rae_out_t;

  // Divider request: the dividend is left aligned so that its top len bits
  // hold the value to divide.
  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  dividend;
    logic [TIME_W-1:0] divisor;
    logic [CNT_W-1:0]  len;
  } rae_div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } rae_div_rsp_t;

endpackage

// ===== hw/rtl/rae_div.sv =====
// ----------------------------------------------------------------------------
// rae_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rae_div
  import rae_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  rae_div_req_t req,
  output rae_div_rsp_t rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [TIME_W-1:0] dvs_r, dvs_nxt;
  logic [TIME_W:0]   rem_sh;
  logic [TIME_W:0]   rem_sub;
  logic              ge;

  assign rem_sh  = {rem_r, quo_r[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.len;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so its top bit drops out.
      rem_nxt = ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

// ===== hw/rtl/retriggerable_alpha_envelope.sv =====
// ----------------------------------------------------------------------------
// retriggerable_alpha_envelope
// Attack-hold-release envelope on a colour's alpha, driven by trigger and
// 10 ms tick words, with a sequencer around one shared divider.
// ----------------------------------------------------------------------------
//   channel  direction  handshake          word
//   in_      input      valid / stall      rae_in_t
//   out_     output     valid / stall      rae_out_t
//   cfg_     input      valid / ready      index 2 bits, data 14 bits
//
// A trigger word, a tick in idle or hold, and a tick that ends the release need no
// divide. An attack tick divides full scale by the attack time over 10, which comes
// from a reciprocal multiply, to give the step in an 8-bit divide. A release tick
// that stays in release passes through a multiply state and then a 22-bit divide
// by the release time.
// Input is stalled from acceptance until the result enters the output register,
// which holds it while out_stall is high. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module retriggerable_alpha_envelope
  import rae_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rae_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rae_out_t          out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [TIME_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_MUL,
    ST_RDIV,
    ST_PUSH
  } state_t;

  state_t             state_r, state_nxt;
  phase_t             phase_r, phase_nxt;
  logic [TIME_W-1:0]  elapsed_r, elapsed_nxt;
  logic               pending_r, pending_nxt;
  logic [COLOR_W-1:0] red_r, red_nxt;
  logic [COLOR_W-1:0] green_r, green_nxt;
  logic [COLOR_W-1:0] blue_r, blue_nxt;
  logic [COLOR_W-1:0] alpha_r, alpha_nxt;
  logic [COLOR_W-1:0] tgt_r, tgt_nxt;
  logic [TIME_W-1:0]  attack_r, attack_nxt;
  logic [TIME_W-1:0]  release_r, release_nxt;
  logic [TIME_W-1:0]  hold_r, hold_nxt;
  logic               out_valid_r, out_valid_nxt;
  rae_out_t           out_data_r, out_data_nxt;

  rae_div_req_t       div_req;
  rae_div_rsp_t       div_rsp;

  logic [TIME_W-1:0]  e_sum;
  logic [TIME_W-1:0]  e_sat;
  logic [NUM_W-1:0]   prod;
  logic [TIME_W+15:0] att_prod;
  logic [TIME_W+15-RECIP10_SH:0] att_q;
  logic [TIME_W-1:0]  att_div;
  logic [COLOR_W:0]   att_sum;

  rae_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign e_sum    = elapsed_r + TICK_MS;
  assign e_sat    = (e_sum > ELAPSED_MAX) ? ELAPSED_MAX : e_sum;
  assign prod     = NUM_W'(tgt_r) * NUM_W'(elapsed_r);
  assign att_prod = (TIME_W+16)'(attack_r) * (TIME_W+16)'(RECIP10);
  assign att_q    = att_prod[TIME_W+15:RECIP10_SH];
  assign att_div  = (att_q == '0) ? TIME_W'(1) : TIME_W'(att_q);
  assign att_sum  = {1'b0, alpha_r} + {1'b0, div_rsp.quot[COLOR_W-1:0]};

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    elapsed_nxt   = elapsed_r;
    pending_nxt   = pending_r;
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    alpha_nxt     = alpha_r;
    tgt_nxt       = tgt_r;
    attack_nxt    = attack_r;
    release_nxt   = release_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    div_req       = '0;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_ATTACK:  attack_nxt  = cfg_data;
        CFG_RELEASE: release_nxt = cfg_data;
        CFG_HOLD:    hold_nxt    = cfg_data;
        default:     ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          tgt_nxt   = in_data.target_alpha;
          state_nxt = ST_PUSH;
          if (in_data.op) begin
            pending_nxt = 1'b1;
            red_nxt     = in_data.target_red;
            green_nxt   = in_data.target_green;
            blue_nxt    = in_data.target_blue;
          end else begin
            elapsed_nxt = e_sat;
            case (phase_r)
              PH_IDLE: begin
                if (pending_r) begin
                  pending_nxt = 1'b0;
                  phase_nxt   = PH_ATTACK;
                  elapsed_nxt = '0;
                end
              end
              PH_ATTACK: begin
                div_req.start    = 1'b1;
                div_req.dividend = {FULL_SCALE, 14'b0};
                div_req.divisor  = att_div;
                div_req.len      = CNT_W'(COLOR_W);
                state_nxt        = ST_STEP;
              end
              PH_HOLD: begin
                if (e_sat > hold_r) begin
                  phase_nxt   = PH_RELEASE;
                  elapsed_nxt = '0;
                end
                // A retrigger out of hold keeps the elapsed count, unless the hold has just ended and cleared it.
                if (pending_r) begin
                  pending_nxt = 1'b0;
                  phase_nxt   = PH_ATTACK;
                end
              end
              PH_RELEASE: begin
                if (e_sat > release_r) begin
                  phase_nxt   = PH_IDLE;
                  elapsed_nxt = '0;
                  if (pending_r) begin
                    pending_nxt = 1'b0;
                    phase_nxt   = PH_ATTACK;
                  end
                end else begin
                  state_nxt = ST_MUL;
                end
              end
              default: ;
            endcase
          end
        end
      end

      ST_STEP: begin
        if (div_rsp.done) begin
          if (att_sum > {1'b0, tgt_r}) begin
            alpha_nxt = tgt_r;
            phase_nxt = PH_HOLD;
          end else begin
            alpha_nxt = att_sum[COLOR_W-1:0];
          end
          if (pending_r) begin
            pending_nxt = 1'b0;
            phase_nxt   = PH_ATTACK;
            elapsed_nxt = '0;
          end
          state_nxt = ST_PUSH;
        end
      end

      ST_MUL: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod;
        div_req.divisor  = (release_r == '0) ? TIME_W'(1) : release_r;
        div_req.len      = CNT_W'(NUM_W);
        state_nxt        = ST_RDIV;
      end

      ST_RDIV: begin
        if (div_rsp.done) begin
          alpha_nxt = tgt_r - div_rsp.quot[COLOR_W-1:0];
          if (pending_r) begin
            pending_nxt = 1'b0;
            phase_nxt   = PH_ATTACK;
            elapsed_nxt = '0;
          end
          state_nxt = ST_PUSH;
        end
      end

      ST_PUSH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.out_red   = red_r;
          out_data_nxt.out_green = green_r;
          out_data_nxt.out_blue  = blue_r;
          out_data_nxt.out_alpha = alpha_r;
          out_data_nxt.phase     = phase_r;
          state_nxt              = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_IDLE;
      elapsed_r   <= '0;
      pending_r   <= 1'b0;
      red_r       <= '0;
      green_r     <= '0;
      blue_r      <= '0;
      alpha_r     <= '0;
      attack_r    <= ATTACK_RST;
      release_r   <= RELEASE_RST;
      hold_r      <= HOLD_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      elapsed_r   <= elapsed_nxt;
      pending_r   <= pending_nxt;
      red_r       <= red_nxt;
      green_r     <= green_nxt;
      blue_r      <= blue_nxt;
      alpha_r     <= alpha_nxt;
      attack_r    <= attack_nxt;
      release_r   <= release_nxt;
      hold_r      <= hold_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tgt_r      <= tgt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

// ===== hw/rtl/rae_checker.sv =====
// ----------------------------------------------------------------------------
// rae_checker
// Port-level assertions for the retriggerable alpha envelope.
// ----------------------------------------------------------------------------
module rae_checker
  import rae_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input rae_out_t out_data
);

  // A held result word must not move.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // One word at a time: the block is busy right after it takes a word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after acceptance");

  // A new result only appears at the end of work on an accepted word.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind retriggerable_alpha_envelope rae_checker u_rae_checker (.*);

// ===== test/retriggerable_alpha_envelope_tb.sv =====
// ----------------------------------------------------------------------------
// retriggerable_alpha_envelope_tb
// Drives trigger and tick words into the envelope with random gaps and
// output stalls, predicts each result word from its own copy of the
// envelope state and compares every field as the words come out.
// ----------------------------------------------------------------------------
module retriggerable_alpha_envelope_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rae_pkg::*;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_TRIGGER = 1'b1;
  localparam int   IDLE_LIMIT = 2000;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  rae_in_t           in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  rae_out_t          out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = CFG_ATTACK;
  logic [TIME_W-1:0] cfg_data  = '0;

  retriggerable_alpha_envelope uut (.*);

  // Envelope state as the block should hold it.
  logic [TIME_W-1:0]  attack_ms;
  logic [TIME_W-1:0]  release_ms;
  logic [TIME_W-1:0]  hold_ms;
  phase_t             env_ph;
  int                 ms_count;
  bit                 retrig;
  logic [COLOR_W-1:0] lat_red;
  logic [COLOR_W-1:0] lat_green;
  logic [COLOR_W-1:0] lat_blue;
  logic [COLOR_W-1:0] env_alpha;

  rae_out_t color_fifo[$];
  rae_out_t want;
  bit       failed;
  int       max_gap;
  int       max_stall;
  int       stall_left;
  int       idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic rae_out_t envelope_step(rae_in_t w);
    int       tgt;
    int       div;
    int       level;
    phase_t   was;
    rae_out_t r;
    tgt = w.target_alpha;
    if (w.op == OP_TRIGGER) begin
      retrig    = 1'b1;
      lat_red   = w.target_red;
      lat_green = w.target_green;
      lat_blue  = w.target_blue;
    end else begin
      ms_count = ms_count + int'(TICK_MS);
      if (ms_count > int'(ELAPSED_MAX)) ms_count = int'(ELAPSED_MAX);
      was = env_ph;
      case (env_ph)
        PH_ATTACK: begin
          div = int'(attack_ms) / int'(TICK_MS);
          if (div == 0) div = 1;
          level = int'(env_alpha) + int'(FULL_SCALE) / div;
          if (level > tgt) begin
            env_alpha = w.target_alpha;
            env_ph    = PH_HOLD;
          end else begin
            env_alpha = level[7:0];
          end
        end
        PH_HOLD: begin
          if (ms_count > int'(hold_ms)) begin
            env_ph   = PH_RELEASE;
            ms_count = 0;
          end
        end
        PH_RELEASE: begin
          if (ms_count > int'(release_ms)) begin
            env_ph   = PH_IDLE;
            ms_count = 0;
          end else begin
            div   = (release_ms == 0) ? 1 : int'(release_ms);
            level = tgt - (tgt * ms_count) / div;
            env_alpha = level[7:0];
          end
        end
        default: begin
        end
      endcase
      // A pending trigger restarts the attack; only hold keeps the time count.
      if (retrig) begin
        retrig = 1'b0;
        env_ph = PH_ATTACK;
        if (was != PH_HOLD) ms_count = 0;
      end
    end
    r.out_red   = lat_red;
    r.out_green = lat_green;
    r.out_blue  = lat_blue;
    r.out_alpha = env_alpha;
    r.phase     = env_ph;
    return r;
  endfunction

  task automatic check_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
    if (got_val !== exp_val) begin
      failed = 1'b1;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, exp_val, got_val);
    end
  endtask

  // Result side: checks each word and draws a stall after it.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (color_fifo.size() == 0) begin
          failed = 1'b1;
          $display("%0t ns: word %h with none expected", $time, out_data);
        end else begin
          want = color_fifo.pop_front();
          check_field("out_red", want.out_red, out_data.out_red);
          check_field("out_green", want.out_green, out_data.out_green);
          check_field("out_blue", want.out_blue, out_data.out_blue);
          check_field("out_alpha", want.out_alpha, out_data.out_alpha);
          check_field("phase", 8'(want.phase), 8'(out_data.phase));
        end
        stall_left = $urandom_range(0, max_stall);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[retriggerable_alpha_envelope] ERROR");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  task automatic send_word(rae_in_t w);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    color_fifo.push_back(envelope_step(w));
  endtask

  task automatic send_tick(logic [7:0] peak);
    rae_in_t w;
    w.op           = OP_TICK;
    w.target_red   = 8'($urandom);
    w.target_green = 8'($urandom);
    w.target_blue  = 8'($urandom);
    w.target_alpha = peak;
    send_word(w);
  endtask

  task automatic send_trigger(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    rae_in_t w;
    w.op           = OP_TRIGGER;
    w.target_red   = red;
    w.target_green = green;
    w.target_blue  = blue;
    w.target_alpha = 8'($urandom);
    send_word(w);
  endtask

  // Lowers valid and waits until every predicted word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (color_fifo.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [TIME_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ATTACK:  attack_ms  = val;
      CFG_RELEASE: release_ms = val;
      CFG_HOLD:    hold_ms    = val;
      default: begin
      end
    endcase
  endtask

  task automatic test_reset_defaults();
    send_trigger(8'hFF, 8'h00, 8'hAA);
    repeat (3) send_tick(8'hFF);
  endtask

  // Attack times under 10 ms give a full-scale step; a zero release time
  // drops straight to idle.
  task automatic test_short_attack_zero_release();
    write_reg(CFG_ATTACK, 14'd0);
    write_reg(CFG_HOLD, 14'd0);
    write_reg(CFG_RELEASE, 14'd0);
    repeat (3) send_tick(8'd0);
    send_trigger(8'h55, 8'hAA, 8'h00);
    send_tick(8'd200);
    send_tick(8'd200);
  endtask

  task automatic test_clamp_and_retrigger();
    write_reg(CFG_ATTACK, 14'd20);
    write_reg(CFG_HOLD, 14'h3FFF);
    write_reg(CFG_RELEASE, 14'h3FFF);
    send_trigger(8'h00, 8'hFF, 8'h55);
    send_tick(8'd255);
    send_tick(8'd100);
    send_trigger(8'hAA, 8'h55, 8'hFF);
    send_tick(8'd255);
    send_tick(8'd255);
    send_trigger(8'hFF, 8'hFF, 8'hFF);
    send_tick(8'd255);
    send_tick(8'd0);
  endtask

  task automatic test_release_fall();
    write_reg(CFG_ATTACK, 14'd10000);
    write_reg(CFG_HOLD, 14'd0);
    write_reg(CFG_RELEASE, 14'd30);
    repeat (5) send_tick(8'd255);
    send_trigger(8'h00, 8'h00, 8'h00);
    send_tick(8'd255);
    send_tick(8'd255);
  endtask

  task automatic test_random_envelopes();
    logic [7:0] peak;
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_ATTACK, ($urandom_range(0, 5) == 0) ?
                TIME_W'($urandom_range(0, 16383)) : TIME_W'($urandom_range(10, 300)));
      write_reg(CFG_RELEASE, ($urandom_range(0, 5) == 0) ?
                TIME_W'(0) : TIME_W'($urandom_range(10, 200)));
      write_reg(CFG_HOLD, TIME_W'($urandom_range(0, 150)));
      max_gap   = (p % 3 == 1) ? 0 : 9;
      max_stall = (p % 2 == 1) ? 0 : 9;
      peak      = 8'($urandom);
      for (int n = 0; n < 100; n++) begin
        if (p == 3 && n == 50) drain();
        if ($urandom_range(0, 17) == 0) begin
          send_trigger(8'($urandom), 8'($urandom), 8'($urandom));
        end else begin
          if ($urandom_range(0, 24) == 0) peak = 8'($urandom);
          send_tick(peak);
        end
      end
    end
  endtask

  initial begin
    attack_ms  = ATTACK_RST;
    release_ms = RELEASE_RST;
    hold_ms    = HOLD_RST;
    env_ph     = PH_IDLE;
    ms_count   = 0;
    retrig     = 1'b0;
    lat_red    = '0;
    lat_green  = '0;
    lat_blue   = '0;
    env_alpha  = '0;
    failed     = 1'b0;
    max_gap    = 9;
    max_stall  = 9;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_short_attack_zero_release();
    test_clamp_and_retrigger();
    test_release_fall();
    test_random_envelopes();
    drain();
    repeat (40) @(posedge clk);
    if (!failed) begin
      $display("[retriggerable_alpha_envelope] OK");
    end else begin
      $display("[retriggerable_alpha_envelope] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rae_pkg.sv
hw/rtl/rae_div.sv
hw/rtl/retriggerable_alpha_envelope.sv
hw/rtl/rae_checker.sv
test/retriggerable_alpha_envelope_tb.sv
